>>> rtl/zka_pkg.sv
// ----------------------------------------------------------------------------
// zka_pkg
// shared types and constants of the zobrist key accumulator
// ----------------------------------------------------------------------------
package zka_pkg;

    localparam int ACTION_W = 3;
    localparam int ID_W     = 4;
    localparam int SQ_W     = 6;
    localparam int CAT_W    = 3;
    localparam int IDX_W    = 10;
    localparam int KEY_W    = 64;
    localparam int HALF_W   = 32;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // feature kinds
    localparam logic [ACTION_W-1:0] ACT_PIECE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TURN   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CASTLE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SETUP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_EP     = 3'd4;

    // key categories
    localparam logic [CAT_W-1:0] CAT_NONE   = 3'd0;
    localparam logic [CAT_W-1:0] CAT_PIECE  = 3'd1;
    localparam logic [CAT_W-1:0] CAT_TURN   = 3'd2;
    localparam logic [CAT_W-1:0] CAT_CASTLE = 3'd3;
    localparam logic [CAT_W-1:0] CAT_SETUP  = 3'd4;
    localparam logic [CAT_W-1:0] CAT_EP     = 3'd5;

    localparam int CAT_SHIFT = 48;

    localparam logic [KEY_W-1:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam logic [KEY_W-1:0] KEY_SEED = 64'hA7E4D3C2B1908F61;

    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    typedef struct packed {
        logic [CAT_W-1:0] cat;
        logic [IDX_W-1:0] index;
        logic             ok;
        logic             last;
    } zka_feat_t;

endpackage

>>> rtl/zka_front.sv
// ----------------------------------------------------------------------------
// zka_front
// accepts feature items, checks bounds and forms category and table index
// ----------------------------------------------------------------------------
module zka_front
    import zka_pkg::*;
#(
    parameter int SQUARES         = 64,
    parameter int PIECE_COLOR_IDS = 16,
    parameter int COLORS          = 2,
    parameter int CASTLE_IDS      = 16,
    parameter int SETUP_IDS       = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action, item_id, square
    input  logic                s_tlast,
    output logic                q_push,
    input  logic                q_full,
    output zka_feat_t           q_data
);

    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     item_id;
    logic [SQ_W-1:0]     square;
    logic                id_pc_ok;
    logic                id_col_ok;
    logic                id_cas_ok;
    logic                id_set_ok;
    logic                sq_ok;
    logic [IDX_W-1:0]    sq_index;
    logic                accept;

    zka_feat_t feat_reg, feat_next;
    logic      valid_reg, valid_next;

    assign action  = s_tdata[ACTION_W-1:0];
    assign item_id = s_tdata[ACTION_W +: ID_W];
    assign square  = s_tdata[ACTION_W+ID_W +: SQ_W];

    assign id_pc_ok  = {1'b0, item_id} < (ID_W+1)'(PIECE_COLOR_IDS);
    assign id_col_ok = {1'b0, item_id} < (ID_W+1)'(COLORS);
    assign id_cas_ok = {1'b0, item_id} < (ID_W+1)'(CASTLE_IDS);
    assign id_set_ok = {1'b0, item_id} < (ID_W+1)'(SETUP_IDS);
    assign sq_ok     = {1'b0, square} < (SQ_W+1)'(SQUARES);
    assign sq_index  = IDX_W'(item_id) * IDX_W'(SQUARES) + IDX_W'(square);

    assign q_push   = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_data   = feat_reg;

    always_comb begin
        feat_next      = feat_reg;
        feat_next.last = s_tlast;
        case (action)
            ACT_PIECE: begin
                feat_next.cat   = CAT_PIECE;
                feat_next.index = sq_index;
                feat_next.ok    = id_pc_ok && sq_ok;
            end
            ACT_TURN: begin
                feat_next.cat   = CAT_TURN;
                feat_next.index = IDX_W'(item_id);
                feat_next.ok    = id_col_ok;
            end
            ACT_CASTLE: begin
                feat_next.cat   = CAT_CASTLE;
                feat_next.index = IDX_W'(item_id);
                feat_next.ok    = id_cas_ok;
            end
            ACT_SETUP: begin
                feat_next.cat   = CAT_SETUP;
                feat_next.index = IDX_W'(item_id);
                feat_next.ok    = id_set_ok;
            end
            ACT_EP: begin
                feat_next.cat   = CAT_EP;
                feat_next.index = sq_index;
                feat_next.ok    = id_col_ok && sq_ok;
            end
            default: begin
                feat_next.cat   = CAT_NONE;
                feat_next.index = '0;
                feat_next.ok    = 1'b0;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            feat_reg <= feat_next;
        end
    end

endmodule

>>> rtl/zka_queue.sv
// ----------------------------------------------------------------------------
// zka_queue
// short fifo of classified features between front and back
// ----------------------------------------------------------------------------
module zka_queue
    import zka_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  zka_feat_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output zka_feat_t pop_data
);

    zka_feat_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/zka_back.sv
// ----------------------------------------------------------------------------
// zka_back
// splitmix64 key pipeline, running xor accumulator and result register
// ----------------------------------------------------------------------------
module zka_back
    import zka_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    output logic                q_pop,
    input  logic                q_empty,
    input  zka_feat_t           q_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // key
    output logic                m_tuser    // bad_item
);

    logic adv;

    // stage 1: seed, add, first xor-shift
    logic             v1_reg, v1_next;
    logic             ok1_reg, last1_reg;
    logic [KEY_W-1:0] x1_reg, x1_next;
    logic [KEY_W-1:0] seed_v;
    logic [KEY_W-1:0] add_v;

    // stage 2: partial products with first multiplier
    logic              v2_reg, ok2_reg, last2_reg;
    logic [KEY_W-1:0]  p1_ll_reg, p1_ll_next;
    logic [HALF_W-1:0] p1_lh_reg, p1_lh_next;
    logic [HALF_W-1:0] p1_hl_reg, p1_hl_next;

    // stage 3: sum, second xor-shift
    logic             v3_reg, ok3_reg, last3_reg;
    logic [KEY_W-1:0] x2_reg, x2_next;
    logic [KEY_W-1:0] y_v;

    // stage 4: partial products with second multiplier
    logic              v4_reg, ok4_reg, last4_reg;
    logic [KEY_W-1:0]  p2_ll_reg, p2_ll_next;
    logic [HALF_W-1:0] p2_lh_reg, p2_lh_next;
    logic [HALF_W-1:0] p2_hl_reg, p2_hl_next;

    // stage 5: sum, final xor-shift
    logic             v5_reg, ok5_reg, last5_reg;
    logic [KEY_W-1:0] key5_reg, key5_next;
    logic [KEY_W-1:0] z_v;

    // accumulator and result
    logic [KEY_W-1:0]    acc_reg, acc_next;
    logic                err_reg, err_next;
    logic [KEY_W-1:0]    acc_upd;
    logic                err_upd;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_key_reg, out_key_next;
    logic                out_bad_reg, out_bad_next;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tuser  = out_bad_reg;

    always_comb begin
        seed_v  = KEY_SEED ^ (KEY_W'(q_data.cat) << CAT_SHIFT) ^ KEY_W'(q_data.index);
        add_v   = seed_v + MIX_ADD;
        x1_next = add_v ^ (add_v >> MIX_SH1);
        v1_next = !q_empty;
    end

    always_comb begin
        p1_ll_next = KEY_W'(x1_reg[HALF_W-1:0] * MIX_MUL1[HALF_W-1:0]);
        p1_lh_next = HALF_W'(x1_reg[HALF_W-1:0] * MIX_MUL1[KEY_W-1:HALF_W]);
        p1_hl_next = HALF_W'(x1_reg[KEY_W-1:HALF_W] * MIX_MUL1[HALF_W-1:0]);
    end

    always_comb begin
        y_v     = p1_ll_reg + {p1_lh_reg + p1_hl_reg, {HALF_W{1'b0}}};
        x2_next = y_v ^ (y_v >> MIX_SH2);
    end

    always_comb begin
        p2_ll_next = KEY_W'(x2_reg[HALF_W-1:0] * MIX_MUL2[HALF_W-1:0]);
        p2_lh_next = HALF_W'(x2_reg[HALF_W-1:0] * MIX_MUL2[KEY_W-1:HALF_W]);
        p2_hl_next = HALF_W'(x2_reg[KEY_W-1:HALF_W] * MIX_MUL2[HALF_W-1:0]);
    end

    always_comb begin
        z_v       = p2_ll_reg + {p2_lh_reg + p2_hl_reg, {HALF_W{1'b0}}};
        key5_next = z_v ^ (z_v >> MIX_SH3);
    end

    always_comb begin
        acc_upd        = acc_reg ^ (ok5_reg ? key5_reg : '0);
        err_upd        = err_reg || !ok5_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_key_next   = out_key_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (adv && v5_reg) begin
            if (last5_reg) begin
                acc_next       = '0;
                err_next       = 1'b0;
                out_key_next   = acc_upd;
                out_bad_next   = err_upd;
                out_valid_next = 1'b1;
            end else begin
                acc_next = acc_upd;
                err_next = err_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg <= v1_next;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg    <= x1_next;
            ok1_reg   <= q_data.ok;
            last1_reg <= q_data.last;

            p1_ll_reg <= p1_ll_next;
            p1_lh_reg <= p1_lh_next;
            p1_hl_reg <= p1_hl_next;
            ok2_reg   <= ok1_reg;
            last2_reg <= last1_reg;

            x2_reg    <= x2_next;
            ok3_reg   <= ok2_reg;
            last3_reg <= last2_reg;

            p2_ll_reg <= p2_ll_next;
            p2_lh_reg <= p2_lh_next;
            p2_hl_reg <= p2_hl_next;
            ok4_reg   <= ok3_reg;
            last4_reg <= last3_reg;

            key5_reg  <= key5_next;
            ok5_reg   <= ok4_reg;
            last5_reg <= last4_reg;
        end
        out_key_reg <= out_key_next;
        out_bad_reg <= out_bad_next;
    end

endmodule

>>> rtl/zobrist_key_accumulator_unit.sv
// ----------------------------------------------------------------------------
// zobrist_key_accumulator_unit
// builds a 64-bit zobrist position key from a stream of position features
//
// s_ channel: one feature item per transfer, tdata = action, item_id, square
// from bit 0 up, tlast marks the final feature of a position.
// m_ channel: one result per position, tdata = key, tuser = bad_item.
// each feature key is derived on the fly by a five-stage splitmix64
// pipeline (two 64-bit multiplies, each split into 32x32 partial products
// over two stages) and xored into a running key.
// throughput: one item per cycle while the result side keeps up.
// once the last item of a position is accepted, its key passes the classify
// register, the queue, the five key stages and the result register before it
// appears on m_tvalid.
// a stalled m_tready freezes the key pipeline; the four-entry queue and the
// front register keep taking items until they fill.
// reset clears the running key, the error flag, the queue and all valids.
// ----------------------------------------------------------------------------
module zobrist_key_accumulator_unit
    import zka_pkg::*;
#(
    parameter int SQUARES         = 64,
    parameter int PIECE_COLOR_IDS = 16,
    parameter int COLORS          = 2,
    parameter int CASTLE_IDS      = 16,
    parameter int SETUP_IDS       = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action[2:0], item_id[6:3], square[12:7]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // key[63:0]
    output logic                m_tuser    // bad_item
);

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    zka_feat_t q_wr_data;
    zka_feat_t q_rd_data;

    zka_front #(
        .SQUARES         (SQUARES),
        .PIECE_COLOR_IDS (PIECE_COLOR_IDS),
        .COLORS          (COLORS),
        .CASTLE_IDS      (CASTLE_IDS),
        .SETUP_IDS       (SETUP_IDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_wr_data)
    );

    zka_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rd_data)
    );

    zka_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_data   (q_rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
